### rtl/core/ppid_pkg.sv
// ----------------------------------------------------------------------------
// ppid_pkg
// shared constants, configuration layout and controller-to-datapath commands
// for the positional pid controller core
// ----------------------------------------------------------------------------
`default_nettype none

package ppid_pkg;

  // default parameter values
  localparam int DATA_WIDTH_DEF  = 16;
  localparam int GAIN_FRAC_DEF   = 8;

  // fixed formats
  localparam int INTEG_FRAC_BITS = 16;
  localparam int INTEG_W         = 32;
  localparam int GAIN_W          = 16;
  localparam int LIMIT_W         = 31;
  localparam int DRIVE_W         = 32;

  // configuration port
  localparam int CFG_INDEX_W     = 3;
  localparam int CFG_DATA_W      = 31;

  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_RATE    = 3'd5;

  // about 0.005 s in q0.16 and the matching rate in hertz
  localparam logic [GAIN_W-1:0] SAMPLE_PERIOD_RESET = 16'd328;
  localparam logic [GAIN_W-1:0] SAMPLE_RATE_RESET   = 16'd200;

  typedef struct packed {
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [LIMIT_W-1:0] integral_limit;
    logic [GAIN_W-1:0]  sample_period;
    logic [GAIN_W-1:0]  sample_rate;
  } ppid_cfg_t;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_PERIOD = 3'd0,
    MUL_RATE   = 3'd1,
    MUL_KD     = 3'd2,
    MUL_KP     = 3'd3,
    MUL_KI     = 3'd4
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD   = 2'd0,
    ACC_LOAD_D = 2'd1,
    ACC_ADD_P  = 2'd2,
    ACC_ADD_I  = 2'd3
  } acc_op_t;

  typedef struct packed {
    logic     load_in;
    logic     clear_hist;
    logic     hist_upd;
    logic     integ_upd;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic integ_in_range;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/ppid_if.sv
// ----------------------------------------------------------------------------
// ppid channel interfaces
// valid/ready channels for sample transactions and result transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface ppid_sample_if #(
  parameter int DATA_WIDTH = ppid_pkg::DATA_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [DATA_WIDTH-1:0] setpoint;
  logic signed [DATA_WIDTH-1:0] measurement;

  modport source (output valid, output op, output setpoint, output measurement,
                  input ready);
  modport sink   (input valid, input op, input setpoint, input measurement,
                  output ready);
endinterface

interface ppid_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [ppid_pkg::DRIVE_W-1:0] drive;
  logic                                integral_clamped;

  modport source (output valid, output drive, output integral_clamped, input ready);
  modport sink   (input valid, input drive, input integral_clamped, output ready);
endinterface

`default_nettype wire

### rtl/core/ppid_regs.sv
// ----------------------------------------------------------------------------
// ppid_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
`default_nettype none

module ppid_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ppid_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ppid_pkg::CFG_DATA_W-1:0]  cfg_data,
  output ppid_pkg::ppid_cfg_t              cfg
);
  import ppid_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= '0;
      cfg.integ_gain     <= '0;
      cfg.deriv_gain     <= '0;
      cfg.integral_limit <= '0;
      cfg.sample_period  <= SAMPLE_PERIOD_RESET;
      cfg.sample_rate    <= SAMPLE_RATE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PROP_GAIN:      cfg.prop_gain      <= cfg_data[GAIN_W-1:0];
        REG_INTEG_GAIN:     cfg.integ_gain     <= cfg_data[GAIN_W-1:0];
        REG_DERIV_GAIN:     cfg.deriv_gain     <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[LIMIT_W-1:0];
        REG_SAMPLE_PERIOD:  cfg.sample_period  <= cfg_data[GAIN_W-1:0];
        REG_SAMPLE_RATE:    cfg.sample_rate    <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/ppid_ctrl.sv
// ----------------------------------------------------------------------------
// ppid_ctrl
// sequencer that steps the datapath through the five shared products
// ----------------------------------------------------------------------------
`default_nettype none

module ppid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ppid_pkg::dp_cmd_t cmd
);
  import ppid_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PERIOD = 8'b0000_0010,
    S_INTEG  = 8'b0000_0100,
    S_DERIV  = 8'b0000_1000,
    S_DTERM  = 8'b0001_0000,
    S_PTERM  = 8'b0010_0000,
    S_ITERM  = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.mul_sel = MUL_PERIOD;
    cmd.acc_op  = ACC_HOLD;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in    = 1'b1;
          cmd.clear_hist = in_op;
          state_next     = in_op ? S_OUT : S_PERIOD;
        end
      end
      S_PERIOD: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = MUL_PERIOD;
        cmd.hist_upd = 1'b1;
        state_next   = S_INTEG;
      end
      S_INTEG: begin
        cmd.integ_upd = 1'b1;
        cmd.mul_en    = 1'b1;
        cmd.mul_sel   = MUL_RATE;
        state_next    = S_DERIV;
      end
      S_DERIV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KD;
        state_next  = S_DTERM;
      end
      S_DTERM: begin
        cmd.acc_op  = ACC_LOAD_D;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KP;
        state_next  = S_PTERM;
      end
      S_PTERM: begin
        cmd.acc_op  = ACC_ADD_P;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_KI;
        state_next  = S_ITERM;
      end
      S_ITERM: begin
        cmd.acc_op = ACC_ADD_I;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.out_load | (out_valid & ~out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ppid_dp.sv
// ----------------------------------------------------------------------------
// ppid_dp
// error history, clamped integrator, shared multiplier and drive accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module ppid_dp #(
  parameter int DATA_WIDTH     = ppid_pkg::DATA_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = ppid_pkg::GAIN_FRAC_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ppid_pkg::dp_cmd_t                    cmd,
  input  ppid_pkg::ppid_cfg_t                  cfg,
  input  logic                                 in_op,
  input  logic signed [DATA_WIDTH-1:0]         setpoint,
  input  logic signed [DATA_WIDTH-1:0]         measurement,
  output logic signed [ppid_pkg::DRIVE_W-1:0]  drive,
  output logic                                 integral_clamped,
  output ppid_pkg::dp_status_t                 status
);
  import ppid_pkg::*;

  localparam int ERR_W   = DATA_WIDTH + 1;
  localparam int DIFF_W  = DATA_WIDTH + 2;
  localparam int DERIV_W = DATA_WIDTH + 19;
  localparam int MB_W    = GAIN_W + 1;
  localparam int MA_W    = (DERIV_W > INTEG_W) ? DERIV_W : INTEG_W;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int SUM_W   = ((ERR_W + MB_W > INTEG_W) ? ERR_W + MB_W : INTEG_W) + 1;
  localparam int DT_W    = (DERIV_W + MB_W > 64) ? 64 : DERIV_W + MB_W;
  localparam int PT_W    = ERR_W + MB_W;
  localparam int IT_W    = INTEG_W + MB_W - INTEG_FRAC_BITS;
  localparam int PI_W    = (PT_W > IT_W) ? PT_W : IT_W;
  localparam int ACC_W   = ((DT_W > PI_W) ? DT_W : PI_W) + 2;
  localparam int WIDE_W  = (PROD_W > 64) ? PROD_W : 64;

  localparam logic signed [WIDE_W-1:0] TERM_SAT     = WIDE_W'(64'sh4000_0000_0000_0000);
  localparam logic signed [WIDE_W-1:0] TERM_SAT_NEG = -TERM_SAT;
  localparam logic signed [ACC_W-1:0]  DRIVE_MAX    = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0]  DRIVE_MIN    = ACC_W'(-64'sd2147483648);

  logic                       op_q;
  logic signed [ERR_W-1:0]    err;
  logic signed [ERR_W-1:0]    prev_err;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [INTEG_W-1:0]  integ;
  logic                       clamp_q;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;

  logic signed [MA_W-1:0]     mul_a;
  logic [GAIN_W-1:0]          mul_b_raw;
  logic signed [MB_W-1:0]     mul_b;

  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    lim_s;
  logic signed [INTEG_W-1:0]  integ_next;
  logic                       clamp_next;

  logic signed [WIDE_W-1:0]   prod_wide;
  logic signed [WIDE_W-1:0]   dsat;
  logic signed [ACC_W-1:0]    acc_next;
  logic signed [ACC_W-1:0]    total;
  logic signed [DRIVE_W-1:0]  drive_sat;

  logic signed [INTEG_W:0]    integ_ext;
  logic signed [INTEG_W:0]    lim_ext;

  // multiplier operand select
  always_comb begin
    case (cmd.mul_sel)
      MUL_PERIOD: begin
        mul_a     = MA_W'(err);
        mul_b_raw = cfg.sample_period;
      end
      MUL_RATE: begin
        mul_a     = MA_W'(diff);
        mul_b_raw = cfg.sample_rate;
      end
      MUL_KD: begin
        mul_a     = MA_W'(prod);
        mul_b_raw = cfg.deriv_gain;
      end
      MUL_KP: begin
        mul_a     = MA_W'(err);
        mul_b_raw = cfg.prop_gain;
      end
      MUL_KI: begin
        mul_a     = MA_W'(integ);
        mul_b_raw = cfg.integ_gain;
      end
      default: begin
        mul_a     = '0;
        mul_b_raw = '0;
      end
    endcase
  end

  assign mul_b = signed'({1'b0, mul_b_raw});

  // integrator add and symmetric clamp
  always_comb begin
    sum   = SUM_W'(integ) + SUM_W'(prod);
    lim_s = SUM_W'(signed'({1'b0, cfg.integral_limit}));
    if (sum >= lim_s) begin
      integ_next = INTEG_W'(lim_s);
      clamp_next = 1'b1;
    end else if (sum <= -lim_s) begin
      integ_next = INTEG_W'(-lim_s);
      clamp_next = 1'b1;
    end else begin
      integ_next = INTEG_W'(sum);
      clamp_next = 1'b0;
    end
  end

  // derivative term limited to +/- 2^62
  always_comb begin
    prod_wide = WIDE_W'(prod);
    if (prod_wide > TERM_SAT) begin
      dsat = TERM_SAT;
    end else if (prod_wide < TERM_SAT_NEG) begin
      dsat = TERM_SAT_NEG;
    end else begin
      dsat = prod_wide;
    end
  end

  always_comb begin
    case (cmd.acc_op)
      ACC_LOAD_D: acc_next = ACC_W'(dsat);
      ACC_ADD_P:  acc_next = acc + ACC_W'(prod);
      ACC_ADD_I:  acc_next = acc + ACC_W'(prod >>> INTEG_FRAC_BITS);
      default:    acc_next = acc;
    endcase
  end

  // floor to integer units and saturate
  always_comb begin
    total = acc >>> GAIN_FRAC_BITS;
    if (total > DRIVE_MAX) begin
      drive_sat = DRIVE_W'(DRIVE_MAX);
    end else if (total < DRIVE_MIN) begin
      drive_sat = DRIVE_W'(DRIVE_MIN);
    end else begin
      drive_sat = DRIVE_W'(total);
    end
  end

  // history registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      integ    <= '0;
    end else if (cmd.clear_hist) begin
      prev_err <= '0;
      integ    <= '0;
    end else begin
      if (cmd.hist_upd) begin
        prev_err <= err;
      end
      if (cmd.integ_upd) begin
        integ <= integ_next;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q <= in_op;
      err  <= ERR_W'(setpoint) - ERR_W'(measurement);
    end
    if (cmd.hist_upd) begin
      diff <= DIFF_W'(err) - DIFF_W'(prev_err);
    end
    if (cmd.integ_upd) begin
      clamp_q <= clamp_next;
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    acc <= acc_next;
    if (cmd.out_load) begin
      drive            <= op_q ? '0 : drive_sat;
      integral_clamped <= op_q ? 1'b0 : clamp_q;
    end
  end

  assign integ_ext             = (INTEG_W + 1)'(integ);
  assign lim_ext               = signed'({2'b00, cfg.integral_limit});
  assign status.op_clear       = op_q;
  assign status.integ_in_range = (integ_ext <= lim_ext) && (integ_ext >= -lim_ext);

endmodule

`default_nettype wire

### rtl/core/positional_pid_controller_core.sv
// ----------------------------------------------------------------------------
// positional_pid_controller_core
// positional pid controller with symmetric integrator clamp, fixed point
// ----------------------------------------------------------------------------
// sequence: a control transaction steps through the five products of the single
//   shared multiplier in turn before its result is loaded; a clear transaction
//   loads a zero result directly; a new transaction is taken only once the
//   previous result has been loaded into the output register
// reset: synchronous, clears history and sequencer, loads register defaults
// ----------------------------------------------------------------------------
`default_nettype none

module positional_pid_controller_core #(
  parameter int DATA_WIDTH     = ppid_pkg::DATA_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = ppid_pkg::GAIN_FRAC_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  ppid_sample_if.sink                      sample,
  ppid_result_if.source                    result,
  input  logic                             cfg_write,
  input  logic [ppid_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [ppid_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import ppid_pkg::*;

  ppid_cfg_t  cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // configuration registers; the user must write them only while idle, not enforced here
  ppid_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer: takes one transaction, walks the products, then loads the
  // output register; a new sample may be taken while a result waits
  ppid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_op     (sample.op),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .cmd       (cmd)
  );

  // datapath: error, integrator with clamp, shared multiplier, accumulator
  ppid_dp #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg              (cfg),
    .in_op            (sample.op),
    .setpoint         (sample.setpoint),
    .measurement      (sample.measurement),
    .drive            (result.drive),
    .integral_clamped (result.integral_clamped),
    .status           (status)
  );

  // only one transaction in the datapath at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sample taken while an item is in flight");

  // loading the output register always presents a result
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> result.valid)
    else $error("output load without valid result");

  // integrator sits inside the clamp window after every update
  a_integ_range: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.integ_upd) |-> status.integ_in_range)
    else $error("integrator outside its limit");

  // a clear transaction yields a zero result
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && status.op_clear) |=>
      (result.drive == '0) && !result.integral_clamped)
    else $error("clear item gave a nonzero result");

endmodule

`default_nettype wire
